### rtl/core/cma_pkg.sv
// Shared constants and types of the centered moving average block.
package cma_pkg;

  localparam int unsigned MAX_WINDOW  = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CFG_W       = 6;

  // Per-cycle command of one sample cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_FWD  = 2'd1,
    CELL_BACK = 2'd2
  } cell_op_e;

endpackage

### rtl/core/cma_if.sv
// Valid/ready channel interfaces for sample words and average words.
interface cma_in_if #(
  parameter int unsigned SampleBits = cma_pkg::SAMPLE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface cma_out_if #(
  parameter int unsigned SampleBits = cma_pkg::SAMPLE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] average;
  logic                         final_result;

  modport source (output valid, output average, output final_result, input ready);
  modport sink   (input valid, input average, input final_result, output ready);
endinterface

### rtl/core/cma_cell.sv
// One sample cell of the ring: holds a sample, takes it from either neighbor.
module cma_cell #(
  parameter int unsigned SampleBits = cma_pkg::SAMPLE_BITS
) (
  input  logic                         clk_i,
  input  cma_pkg::cell_op_e            op_i,
  input  logic signed [SampleBits-1:0] lo_i,
  input  logic signed [SampleBits-1:0] hi_i,
  output logic signed [SampleBits-1:0] data_o
);

  logic signed [SampleBits-1:0] data_q, data_d;

  // Pick the neighbor to take from, or hold
  always_comb begin
    case (op_i)
      cma_pkg::CELL_FWD:  data_d = hi_i;
      cma_pkg::CELL_BACK: data_d = lo_i;
      default:            data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/core/cma_div.sv
// Restoring divider: rounded signed mean of a window sum over its length.
module cma_div #(
  parameter int unsigned SumW       = 21,
  parameter int unsigned LenW       = 6,
  parameter int unsigned SampleBits = cma_pkg::SAMPLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [SumW-1:0]       sum_i,
  input  logic [LenW-1:0]              len_i,
  output logic                         done_o,
  output logic signed [SampleBits-1:0] quot_o
);

  localparam int unsigned NumW = SumW + 1;
  localparam int unsigned DenW = LenW + 1;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  logic [SumW-1:0]       mag;
  logic [DenW:0]         rem_s;
  logic                  ge;
  logic [SampleBits-1:0] q_tr;

  // Dividend is 2|sum| + len, divisor 2 len: rounds half away from zero
  assign mag   = sum_i[SumW-1] ? (~sum_i + SumW'(1)) : sum_i;
  assign rem_s = {rem_q, num_q[NumW-1]};
  assign ge    = rem_s >= {1'b0, den_q};

  // One quotient bit per cycle
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = {mag, 1'b0} + NumW'(len_i);
      rem_d = '0;
      den_d = {len_i, 1'b0};
      neg_d = sum_i[SumW-1];
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? DenW'(rem_s - {1'b0, den_q}) : DenW'(rem_s);
      num_d  = {num_q[NumW-2:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Restore the sign; the rounded mean always fits the sample width
  assign q_tr   = num_q[SampleBits-1:0];
  assign quot_o = neg_q ? $signed(-q_tr) : $signed(q_tr);
  assign done_o = done_q;

endmodule

### rtl/core/centered_moving_average.sv
// Top level of the centered moving average with shrinking window edges.
//
// Channels: in_i takes one signed sample word per item, final_sample marks
// the last sample of a sequence; out_o gives average words, final_result
// marks the last average of the sequence. Both are valid/ready; a word
// moves on a clock edge with valid and ready high. cfg_we_i/cfg_wdata_i
// write the window length (0 acts as 1, above MaxWindow as MaxWindow).
// Samples sit in a ring of MaxWindow cells; a window sum is gathered by
// rotating the ring past cell 0, one sample per cycle, then a restoring
// divider gives the mean. A sample that owes no average is taken and
// in_i.ready stays high. Otherwise the average is loaded once the sum
// of the clipped window (up to MaxWindow samples) is divided; after a
// sample that is not final, the ring then rotates back before in_i.ready
// returns. A final sample flushes up to MaxWindow/2 averages, each after
// the first made by dropping at most one sample from the sum and dividing
// again. The output register lets the block go on while a word waits;
// when the receiver stalls, the next average waits in the divider and the
// block holds. Reset clears the sequence and sets the window length to 1.
module centered_moving_average #(
  parameter int unsigned MaxWindow  = cma_pkg::MAX_WINDOW,
  parameter int unsigned SampleBits = cma_pkg::SAMPLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cma_pkg::CFG_W-1:0] cfg_wdata_i,
  cma_in_if.sink                    in_i,
  cma_out_if.source                 out_o
);

  localparam int unsigned IdxW    = $clog2(MaxWindow);
  localparam int unsigned LenW    = IdxW + 1;
  localparam int unsigned SeenW   = $clog2(2 * MaxWindow);
  localparam int unsigned SumW    = SampleBits + IdxW;
  localparam int unsigned KW      = (LenW > cma_pkg::CFG_W) ? LenW : cma_pkg::CFG_W;
  localparam int unsigned SeenCap = 2 * MaxWindow - 1;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ADD      = 8'b0000_0010,
    ST_DIV_GO   = 8'b0000_0100,
    ST_DIV_WAIT = 8'b0000_1000,
    ST_PUT      = 8'b0001_0000,
    ST_BACK     = 8'b0010_0000,
    ST_SUB      = 8'b0100_0000,
    ST_RESTORE  = 8'b1000_0000
  } state_e;

  state_e                    state_q, state_d;
  logic [cma_pkg::CFG_W-1:0] window_len_q;
  logic [SeenW-1:0]          seen_q, seen_d;
  logic                      last_q, last_d;
  logic [IdxW-1:0]           d_q, d_d;
  logic [IdxW-1:0]           before_q, before_d;
  logic [IdxW-1:0]           lim_q, lim_d;
  logic [IdxW-1:0]           hi_q, hi_d;
  logic [IdxW-1:0]           cur_q, cur_d;
  logic signed [SumW-1:0]    acc_q, acc_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] out_avg_q, out_avg_d;
  logic                      out_fin_q, out_fin_d;

  cma_pkg::cell_op_e            cell_op;
  logic                         cell_load;
  logic signed [SampleBits-1:0] cell_data [MaxWindow];
  logic signed [SampleBits-1:0] cell0_lo;
  logic signed [SumW-1:0]       cell0_ext;

  logic                         div_start;
  logic                         div_done;
  logic signed [SampleBits-1:0] div_quot;

  logic [KW-1:0]    k_raw, k;
  logic [IdxW-1:0]  before_w, after_w, kmax_w;
  logic [SeenW-1:0] seen_n, seen_m1;
  logic [IdxW-1:0]  lim_w, d0, hi_last, hi_run, d_dec, nh;
  logic [LenW-1:0]  sum_db, nh_sum;
  logic             has_out;
  logic             in_accept, out_take, put_ok;

  // Window geometry from the clamped length
  assign k_raw    = KW'(window_len_q);
  assign k        = (k_raw == '0) ? KW'(1) :
                    (k_raw > KW'(MaxWindow)) ? KW'(MaxWindow) : k_raw;
  assign before_w = IdxW'(k >> 1);
  assign after_w  = IdxW'((k - KW'(1)) >> 1);
  assign kmax_w   = IdxW'(k - KW'(1));

  // Sequence position after taking this sample
  assign seen_n  = (seen_q < SeenW'(SeenCap)) ? seen_q + SeenW'(1) : seen_q;
  assign seen_m1 = seen_n - SeenW'(1);
  assign lim_w   = (seen_m1 > SeenW'(MaxWindow - 1)) ? IdxW'(MaxWindow - 1)
                                                     : IdxW'(seen_m1);
  assign has_out = seen_n > SeenW'(after_w);
  assign d0      = (lim_w < after_w) ? lim_w : after_w;
  assign sum_db  = {1'b0, d0} + {1'b0, before_w};
  assign hi_last = (sum_db > {1'b0, lim_w}) ? lim_w : IdxW'(sum_db);
  assign hi_run  = (kmax_w < lim_w) ? kmax_w : lim_w;

  // Newest sample of the next flushed output's window
  assign d_dec  = d_q - IdxW'(1);
  assign nh_sum = {1'b0, d_dec} + {1'b0, before_q};
  assign nh     = (nh_sum > {1'b0, lim_q}) ? lim_q : IdxW'(nh_sum);

  assign in_accept = in_i.valid && in_i.ready;
  assign out_take  = out_valid_q && out_o.ready;
  assign put_ok    = (state_q == ST_PUT) && (!out_valid_q || out_o.ready);

  // Ring of sample cells; cell 0 takes the new sample on a load
  assign cell0_lo  = cell_load ? in_i.sample : cell_data[MaxWindow-1];
  assign cell0_ext = {{IdxW{cell_data[0][SampleBits-1]}}, cell_data[0]};

  for (genvar b = 0; b < MaxWindow; b++) begin : g_cell
    localparam int unsigned Up   = (b + 1) % MaxWindow;
    localparam int unsigned Down = (b + MaxWindow - 1) % MaxWindow;
    cma_cell #(
      .SampleBits (SampleBits)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .lo_i   ((b == 0) ? cell0_lo : cell_data[Down]),
      .hi_i   (cell_data[Up]),
      .data_o (cell_data[b])
    );
  end

  cma_div #(
    .SumW       (SumW),
    .LenW       (LenW),
    .SampleBits (SampleBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (acc_q),
    .len_i   ({1'b0, cur_q} + LenW'(1)),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer: gather, divide, emit, step back
  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    last_d    = last_q;
    d_d       = d_q;
    before_d  = before_q;
    lim_d     = lim_q;
    hi_d      = hi_q;
    cur_d     = cur_q;
    acc_d     = acc_q;
    cell_op   = cma_pkg::CELL_HOLD;
    cell_load = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cell_op   = cma_pkg::CELL_BACK;
          cell_load = 1'b1;
          acc_d     = '0;
          cur_d     = '0;
          before_d  = before_w;
          lim_d     = lim_w;
          last_d    = in_i.final_sample;
          if (in_i.final_sample) begin
            seen_d  = '0;
            d_d     = d0;
            hi_d    = hi_last;
            state_d = ST_ADD;
          end else begin
            seen_d = seen_n;
            d_d    = '0;
            hi_d   = hi_run;
            if (has_out) begin
              state_d = ST_ADD;
            end
          end
        end
      end
      ST_ADD: begin
        cell_op = cma_pkg::CELL_FWD;
        acc_d   = acc_q + cell0_ext;
        if (cur_q == hi_q) begin
          state_d = ST_DIV_GO;
        end else begin
          cur_d = cur_q + IdxW'(1);
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put_ok) begin
          if (!last_q) begin
            state_d = ST_RESTORE;
          end else if (d_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            d_d     = d_dec;
            state_d = (nh < cur_q) ? ST_BACK : ST_DIV_GO;
          end
        end
      end
      ST_BACK: begin
        cell_op = cma_pkg::CELL_BACK;
        state_d = ST_SUB;
      end
      ST_SUB: begin
        acc_d   = acc_q - cell0_ext;
        cur_d   = cur_q - IdxW'(1);
        state_d = ST_DIV_GO;
      end
      ST_RESTORE: begin
        cell_op = cma_pkg::CELL_BACK;
        if (cur_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          cur_d = cur_q - IdxW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: drop a taken word, load a finished average
  always_comb begin
    out_valid_d = out_valid_q;
    out_avg_d   = out_avg_q;
    out_fin_d   = out_fin_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (put_ok) begin
      out_valid_d = 1'b1;
      out_avg_d   = div_quot;
      out_fin_d   = last_q && (d_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= cma_pkg::CFG_W'(1);
      seen_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    d_q       <= d_d;
    before_q  <= before_d;
    lim_q     <= lim_d;
    hi_q      <= hi_d;
    cur_q     <= cur_d;
    acc_q     <= acc_d;
    out_avg_q <= out_avg_d;
    out_fin_q <= out_fin_d;
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.average      = out_avg_q;
  assign out_o.final_result = out_fin_q;

endmodule

### rtl/core/cma_chk.sv
// Port-level checks of the centered moving average, bound to the top level.
module cma_chk #(
  parameter int unsigned SampleBits = cma_pkg::SAMPLE_BITS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_final_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [SampleBits-1:0] out_avg_i,
  input logic                         out_fin_i
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_avg_i) && $stable(out_fin_i))
    else $error("output word changed while stalled");

  // A final sample always owes at least one average
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("input taken right after a final sample");

  // A fresh average that is not the last one keeps the input closed
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) && !out_fin_i |-> !in_ready_i)
    else $error("input open while a sequence is still in work");

endmodule

bind centered_moving_average cma_chk #(
  .SampleBits (SampleBits)
) u_cma_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_final_i  (in_i.final_sample),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_avg_i   (out_o.average),
  .out_fin_i   (out_o.final_result)
);
